/* src/knps_pkg.sv */
// Package for the k-nearest photon select block: types, register indexes and constants.
// Used by the top level and its assertion checker. No dependencies.
package knps_pkg;

  localparam int COORD_W = 24;
  localparam int NORM_W  = 16;
  localparam int DIST_W  = 50;
  localparam int CNT_REG_W = 7;
  localparam int OUT_ID_W = 20;

  typedef enum logic [2:0] {
    REG_QX  = 3'd0,
    REG_QY  = 3'd1,
    REG_QZ  = 3'd2,
    REG_QNX = 3'd3,
    REG_QNY = 3'd4,
    REG_QNZ = 3'd5,
    REG_R2  = 3'd6,
    REG_K   = 3'd7
  } reg_idx_t;

  localparam logic [0:0] REQ_OFFER  = 1'b0;
  localparam logic [0:0] REQ_FINISH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CALC,
    ST_TEST,
    ST_BUILD_NEXT,
    ST_SIFT_RD,
    ST_SIFT_WAIT,
    ST_SIFT_CMP,
    ST_ROOT_RD,
    ST_ROOT_WAIT,
    ST_ROOT_CMP,
    ST_EMIT_RD,
    ST_EMIT_WAIT,
    ST_EMIT_OUT
  } state_t;

  // 0.9 threshold: 10*dot >= 9*2^28.
  localparam logic signed [37:0] DOT_LIMIT_X10 = 38'sd2415919104;

endpackage

/* src/k_nearest_photon_select_top.sv */
// Top level of the k-nearest photon select block: distance and normal test, heap in memory, emit.
// Depends on knps_pkg.
//
// A rejected or appended offer returns to idle after its test. A replacement adds a root read
// and a sift-down through the heap levels; the first one after appends rebuilds the heap
// first with n/2 such sift-downs. A finish emits each item by read, wait, load and hand-off,
// and reads the next item only once the output has taken the last one.
// Reset (synchronous, rst_n low) resets the control state and configuration registers; the heap
// memory is not cleared, since it is only read where it has been written.
module k_nearest_photon_select_top
  import knps_pkg::*;
#(
  parameter int HEAP_DEPTH = 64,
  parameter int ID_BITS    = 20
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [5:0]                 paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_req_type,
  input  logic signed [COORD_W-1:0]  in_cand_x,
  input  logic signed [COORD_W-1:0]  in_cand_y,
  input  logic signed [COORD_W-1:0]  in_cand_z,
  input  logic signed [NORM_W-1:0]   in_cand_normal_x,
  input  logic signed [NORM_W-1:0]   in_cand_normal_y,
  input  logic signed [NORM_W-1:0]   in_cand_normal_z,
  input  logic [ID_BITS-1:0]         in_cand_id,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [OUT_ID_W-1:0]        out_id,
  output logic [DIST_W-1:0]          out_dist_squared,
  output logic                       out_out_valid,
  output logic                       out_last
);

  localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int PW = AW + 2;

  // Configuration registers.
  logic signed [COORD_W-1:0] qx_r, qy_r, qz_r;
  logic signed [NORM_W-1:0]  qnx_r, qny_r, qnz_r;
  logic [DIST_W-1:0]         r2_r;
  logic [CNT_REG_W-1:0]      k_r;
  logic                      wr_en;
  reg_idx_t                  widx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qx_r <= '0; qy_r <= '0; qz_r <= '0;
      qnx_r <= '0; qny_r <= '0; qnz_r <= 16'sd16384;
      r2_r <= '0; k_r <= 7'd64;
    end else if (wr_en && paddr[2:0] == 3'b000) begin
      case (widx)
        REG_QX:  qx_r  <= pwdata[COORD_W-1:0];
        REG_QY:  qy_r  <= pwdata[COORD_W-1:0];
        REG_QZ:  qz_r  <= pwdata[COORD_W-1:0];
        REG_QNX: qnx_r <= pwdata[NORM_W-1:0];
        REG_QNY: qny_r <= pwdata[NORM_W-1:0];
        REG_QNZ: qnz_r <= pwdata[NORM_W-1:0];
        REG_R2:  r2_r  <= pwdata[DIST_W-1:0];
        REG_K:   k_r   <= pwdata[CNT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_QX:  prdata = 64'(qx_r);
      REG_QY:  prdata = 64'(qy_r);
      REG_QZ:  prdata = 64'(qz_r);
      REG_QNX: prdata = 64'(qnx_r);
      REG_QNY: prdata = 64'(qny_r);
      REG_QNZ: prdata = 64'(qnz_r);
      REG_R2:  prdata = 64'(r2_r);
      REG_K:   prdata = 64'(k_r);
      default: prdata = '0;
    endcase
  end

  // Heap memory: one word holds distance and id.
  localparam int MW = DIST_W + ID_BITS;
  logic [MW-1:0] mem [HEAP_DEPTH];
  logic [MW-1:0] rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [MW-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[mem_raddr];
  end

  // Datapath registers.
  state_t state_r, state_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic signed [COORD_W:0] dx_r, dy_r, dz_r;
  logic signed [NORM_W-1:0] cnx_r, cny_r, cnz_r;
  logic [DIST_W-1:0] sx_r, sy_r, sz_r;
  logic signed [2*NORM_W-1:0] px_r, py_r, pz_r;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic [DIST_W-1:0] cand_dist_r, cand_dist_nxt;  // candidate kept across a heap build
  logic [ID_BITS-1:0] cand_id_r, cand_id_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic ordered_r, ordered_nxt;
  logic [CW-1:0] n_r, n_nxt;          // heap size for the current sift
  logic [PW-1:0] pos_r, pos_nxt;      // current sift position
  logic [PW-1:0] bidx_r, bidx_nxt;    // build loop index (next start + 1)
  logic build_r, build_nxt;           // sift belongs to a heap build
  logic [MW-1:0] lch_r, lch_nxt;      // left child word
  logic [PW-1:0] child_r, child_nxt;
  logic [1:0] ph_r, ph_nxt;           // sift read phase
  logic [CW-1:0] ecnt_r, ecnt_nxt;
  logic ov_r, ov_nxt;
  logic [OUT_ID_W-1:0] oid_r, oid_nxt;
  logic [DIST_W-1:0] od_r, od_nxt;
  logic oov_r, oov_nxt, olast_r, olast_nxt;

  logic [CW-1:0] k_eff;
  always_comb begin
    if (k_r == '0) k_eff = CW'(1);
    else if (32'(k_r) > HEAP_DEPTH) k_eff = CW'(HEAP_DEPTH);
    else k_eff = CW'(k_r);
  end

  // The differences and normals are taken while the block waits for an item, so
  // they hold the accepted item's values until its test is done.
  always_ff @(posedge clk) begin
    if (in_ready) begin
      dx_r <= {in_cand_x[COORD_W-1], in_cand_x} - {qx_r[COORD_W-1], qx_r};
      dy_r <= {in_cand_y[COORD_W-1], in_cand_y} - {qy_r[COORD_W-1], qy_r};
      dz_r <= {in_cand_z[COORD_W-1], in_cand_z} - {qz_r[COORD_W-1], qz_r};
      cnx_r <= in_cand_normal_x; cny_r <= in_cand_normal_y; cnz_r <= in_cand_normal_z;
    end
    sx_r <= DIST_W'(dx_r * dx_r);
    sy_r <= DIST_W'(dy_r * dy_r);
    sz_r <= DIST_W'(dz_r * dz_r);
    px_r <= cnx_r * qnx_r;
    py_r <= cny_r * qny_r;
    pz_r <= cnz_r * qnz_r;
  end

  logic [DIST_W+1:0] dsum;
  logic signed [37:0] dot, dot10;
  assign dsum  = {2'b0, sx_r} + {2'b0, sy_r} + {2'b0, sz_r};
  assign dot   = 38'(px_r) + 38'(py_r) + 38'(pz_r);
  assign dot10 = (dot <<< 3) + (dot <<< 1);

  logic calc_ph_r;
  logic [MW-1:0] rch;
  logic [DIST_W-1:0] ld, rd, cd;
  logic use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; held_r <= '0; ordered_r <= 1'b0; ov_r <= 1'b0;
      calc_ph_r <= 1'b0;
    end else begin
      state_r <= state_nxt; held_r <= held_nxt; ordered_r <= ordered_nxt; ov_r <= ov_nxt;
      calc_ph_r <= (state_r == ST_CALC) ? ~calc_ph_r : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt; dist_r <= dist_nxt; n_r <= n_nxt; pos_r <= pos_nxt;
    bidx_r <= bidx_nxt; build_r <= build_nxt; lch_r <= lch_nxt; child_r <= child_nxt;
    ph_r <= ph_nxt; ecnt_r <= ecnt_nxt; oid_r <= oid_nxt; od_r <= od_nxt;
    oov_r <= oov_nxt; olast_r <= olast_nxt;
    cand_dist_r <= cand_dist_nxt; cand_id_r <= cand_id_nxt;
  end

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = ov_r;
  assign out_id = oid_r;
  assign out_dist_squared = od_r;
  assign out_out_valid = oov_r;
  assign out_last = olast_r;

  assign rch = rdata_r;
  assign ld  = lch_r[MW-1:ID_BITS];
  assign rd  = rch[MW-1:ID_BITS];

  always_comb begin
    state_nxt = state_r; id_nxt = id_r; dist_nxt = dist_r; held_nxt = held_r;
    ordered_nxt = ordered_r; n_nxt = n_r; pos_nxt = pos_r; bidx_nxt = bidx_r;
    build_nxt = build_r; lch_nxt = lch_r; child_nxt = child_r; ph_nxt = ph_r;
    ecnt_nxt = ecnt_r; ov_nxt = ov_r; oid_nxt = oid_r; od_nxt = od_r;
    oov_nxt = oov_r; olast_nxt = olast_r;
    cand_dist_nxt = cand_dist_r; cand_id_nxt = cand_id_r;
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0; mem_raddr = '0;
    use_r = 1'b0; cd = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          id_nxt = in_cand_id;
          if (in_req_type == REQ_FINISH) begin
            ecnt_nxt = '0;
            state_nxt = ST_EMIT_RD;
          end else begin
            state_nxt = ST_CALC;
          end
        end
      end
      ST_CALC: if (calc_ph_r) state_nxt = ST_TEST;
      ST_TEST: begin
        dist_nxt = dsum[DIST_W-1:0];
        cand_dist_nxt = dsum[DIST_W-1:0];
        cand_id_nxt = id_r;
        state_nxt = ST_IDLE;
        if (dsum[DIST_W-1:0] <= r2_r && dot10 >= DOT_LIMIT_X10) begin
          if (held_r < k_eff) begin
            mem_we = 1'b1; mem_waddr = AW'(held_r);
            mem_wdata = {dsum[DIST_W-1:0], id_r};
            held_nxt = held_r + CW'(1);
            ordered_nxt = 1'b0;
          end else if (!ordered_r) begin
            n_nxt = held_r; bidx_nxt = PW'(held_r >> 1); build_nxt = 1'b1;
            state_nxt = ST_BUILD_NEXT;
          end else begin
            state_nxt = ST_ROOT_RD;
          end
        end
      end
      ST_BUILD_NEXT: begin
        if (bidx_r == '0) begin
          ordered_nxt = 1'b1; build_nxt = 1'b0; state_nxt = ST_ROOT_RD;
        end else begin
          // Load the entry at the start index as the moving value.
          mem_raddr = AW'(bidx_r - PW'(1));
          pos_nxt = bidx_r - PW'(1);
          bidx_nxt = bidx_r - PW'(1);
          ph_nxt = 2'd3;
          state_nxt = ST_SIFT_WAIT;
        end
      end
      ST_ROOT_RD: begin
        mem_raddr = '0; state_nxt = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: state_nxt = ST_ROOT_CMP;
      ST_ROOT_CMP: begin
        if (cand_dist_r >= rdata_r[MW-1:ID_BITS]) begin
          state_nxt = ST_IDLE;
        end else begin
          dist_nxt = cand_dist_r; id_nxt = cand_id_r;
          pos_nxt = '0; n_nxt = held_r; state_nxt = ST_SIFT_RD;
        end
      end
      ST_SIFT_RD: begin
        // Read the left child; the right child is read in ST_SIFT_WAIT.
        child_nxt = (pos_r << 1) + PW'(1);
        if (((pos_r << 1) + PW'(1)) >= PW'(n_r)) begin
          mem_we = 1'b1; mem_waddr = AW'(pos_r); mem_wdata = {dist_r, id_r};
          state_nxt = build_r ? ST_BUILD_NEXT : ST_IDLE;
        end else begin
          mem_raddr = AW'((pos_r << 1) + PW'(1));
          ph_nxt = 2'd0;
          state_nxt = ST_SIFT_WAIT;
        end
      end
      ST_SIFT_WAIT: begin
        if (ph_r == 2'd3) begin
          // Build start value arrives.
          dist_nxt = rdata_r[MW-1:ID_BITS]; id_nxt = rdata_r[ID_BITS-1:0];
          state_nxt = ST_SIFT_RD;
        end else begin
          // Left child arrives; the right child is read next.
          lch_nxt = rdata_r;
          mem_raddr = AW'(child_r + PW'(1));
          state_nxt = ST_SIFT_CMP;
        end
      end
      ST_SIFT_CMP: begin
        use_r = (child_r + PW'(1) < PW'(n_r)) && (ld < rd);
        cd = use_r ? rd : ld;
        if (dist_r > cd) begin
          mem_we = 1'b1; mem_waddr = AW'(pos_r); mem_wdata = {dist_r, id_r};
          state_nxt = build_r ? ST_BUILD_NEXT : ST_IDLE;
        end else begin
          mem_we = 1'b1; mem_waddr = AW'(pos_r);
          mem_wdata = use_r ? rch : lch_r;
          pos_nxt = use_r ? child_r + PW'(1) : child_r;
          state_nxt = ST_SIFT_RD;
        end
      end
      ST_EMIT_RD: begin
        if (!ov_r) begin
          mem_raddr = AW'(ecnt_r);
          state_nxt = ST_EMIT_WAIT;
        end else if (out_ready) begin
          ov_nxt = 1'b0;
        end
      end
      ST_EMIT_WAIT: begin
        mem_raddr = AW'(ecnt_r);
        state_nxt = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        ov_nxt = 1'b1;
        if (held_r == '0) begin
          oid_nxt = '0; od_nxt = '0; oov_nxt = 1'b0; olast_nxt = 1'b1;
        end else begin
          oid_nxt = OUT_ID_W'(rdata_r[ID_BITS-1:0]);
          od_nxt = rdata_r[MW-1:ID_BITS];
          oov_nxt = 1'b1;
          olast_nxt = (ecnt_r + CW'(1) == held_r);
        end
        ecnt_nxt = ecnt_r + CW'(1);
        if (held_r == '0 || ecnt_r + CW'(1) == held_r) begin
          held_nxt = '0; ordered_nxt = 1'b0; state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_EMIT_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (state_r != ST_EMIT_RD && ov_r && out_ready) ov_nxt = 1'b0;
    if (state_r == ST_EMIT_OUT) ov_nxt = 1'b1;
  end

endmodule

/* src/knps_checker.sv */
// Port-level checker for the k-nearest photon select block, bound to its top level.
// Depends on knps_pkg.
module knps_checker
  import knps_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_out_valid,
  input logic out_last,
  input logic [DIST_W-1:0] out_dist_squared
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dist_squared))
    else $error("result item dropped while stalled");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_valid |-> out_last)
    else $error("empty result not marked last");

  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken in the middle of an emitted run");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind k_nearest_photon_select_top knps_checker u_knps_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_out_valid(out_out_valid),
  .out_last(out_last), .out_dist_squared(out_dist_squared)
);
